// ===== rtl/wedfr_pkg.sv =====
// Shared types, constants and the moving-average step for the weight filter.
// No dependencies; used by the cell, the top level and the bench.
`default_nettype none
package wedfr_pkg;

  localparam int unsigned RingDepthDef = 32;
  localparam int unsigned CfgIdxW      = 3;
  localparam int unsigned CfgDataW     = 32;
  localparam int unsigned NumW         = 43;  // |diff| * 1000 + span / 2
  localparam int unsigned DivSteps     = NumW;
  localparam int unsigned DivCntW      = $clog2(DivSteps);

  // Register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CFG_WEIGHT_ALPHA  = 3'd0,
    CFG_DEADBAND      = 3'd1,
    CFG_RATE_WINDOW   = 3'd2,
    CFG_RATE_ALPHA    = 3'd3,
    CFG_JUMP_LIMIT    = 3'd4,
    CFG_RATE_INTERVAL = 3'd5,
    CFG_MIN_SPAN      = 3'd6,
    CFG_UNUSED        = 3'd7
  } cfg_idx_e;

  localparam logic [16:0] WeightAlphaRst  = 17'd16384;
  localparam logic [30:0] DeadbandRst     = 31'd13;
  localparam logic [31:0] RateWindowRst   = 32'd1000;
  localparam logic [16:0] RateAlphaRst    = 17'd13107;
  localparam logic [30:0] JumpLimitRst    = 31'd1280;
  localparam logic [31:0] RateIntervalRst = 32'd200;
  localparam logic [31:0] MinSpanRst      = 32'd200;
  localparam logic [16:0] AlphaOne        = 17'd65536;

  typedef enum logic [2:0] {
    ST_IDLE, ST_WEIGHT, ST_HOLD, ST_SCAN, ST_MUL, ST_DIV, ST_RATE, ST_DONE
  } state_e;

  // Control of the ring of cells
  typedef struct packed {
    logic en;    // cells load this cycle
    logic push;  // 1: shift in a new entry, 0: rotate towards cell 0
  } chain_ctl_t;

  // One average step: old + round(delta * alpha / 65536), halves away from zero
  function automatic logic signed [31:0] ema_step(input logic signed [31:0] old,
                                                  input logic signed [31:0] target,
                                                  input logic [16:0] alpha);
    logic [16:0]        a;
    logic signed [32:0] delta;
    logic [32:0]        mag;
    logic [49:0]        prod;
    logic [33:0]        q;
    logic [34:0]        res;
    a     = (alpha > AlphaOne) ? AlphaOne : alpha;
    delta = 33'(target) - 33'(old);
    mag   = delta[32] ? 33'(-delta) : 33'(delta);
    prod  = 50'(mag) * 50'(a);
    q     = 34'((prod + 50'd32768) >> 16);
    res   = delta[32] ? (35'(old) - 35'(q)) : (35'(old) + 35'(q));
    return signed'(res[31:0]);
  endfunction

endpackage
`default_nettype wire

// ===== rtl/wedfr_cell.sv =====
// One cell of the sample ring: holds an average and its timestamp.
// Depends on wedfr_pkg for the chain control struct.
`default_nettype none
module wedfr_cell (
  input  wire                      clk_i,
  input  wedfr_pkg::chain_ctl_t    ctl_i,
  input  wire logic signed [31:0]  push_w_i,  // from the newer neighbour
  input  wire logic [31:0]         push_t_i,
  input  wire logic signed [31:0]  rot_w_i,   // from the older neighbour
  input  wire logic [31:0]         rot_t_i,
  output logic signed [31:0]       w_o,
  output logic [31:0]              t_o
);
  import wedfr_pkg::*;

  logic signed [31:0] w_q;
  logic [31:0]        t_q;

  // Payload only, no reset
  always_ff @(posedge clk_i) begin
    if (ctl_i.en) begin
      w_q <= ctl_i.push ? push_w_i : rot_w_i;
      t_q <= ctl_i.push ? push_t_i : rot_t_i;
    end
  end

  assign w_o = w_q;
  assign t_o = t_q;
endmodule
`default_nettype wire

// ===== rtl/weight_ema_deadband_flow_rate_core.sv =====
// Weight smoothing, deadband display and flow-rate estimation, top level.
// Depends on wedfr_pkg and wedfr_cell.
//
// A clear goes straight to the output; a sample passes the weight average and
// the deadband hold. When the rate interval has elapsed, the ring of cells
// rotates once fully past cell 0 to find the reference sample, and the product
// is formed. A rate that passes the span check then goes through the serial
// one-bit-a-cycle divide and the rate average. One item is worked on at a time;
// the next one is taken while the previous result waits in the output register.
`default_nettype none
module weight_ema_deadband_flow_rate_core #(
  parameter int unsigned RING_DEPTH = wedfr_pkg::RingDepthDef
) (
  input  wire                                    clk_i,
  input  wire                                    rst_ni,
  input  wire                                    s_axis_tvalid,
  output logic                                   s_axis_tready,
  input  wire [63:0]                             s_axis_tdata,  // raw_weight, now_ms
  input  wire [0:0]                              s_axis_tuser,  // action
  output logic                                   m_axis_tvalid,
  input  wire                                    m_axis_tready,
  // filtered_weight, shown_weight, raw_rate, smooth_rate
  output logic [127:0]                           m_axis_tdata,
  output logic [0:0]                             m_axis_tuser,  // rate_updated
  input  wire                                    cfg_we_i,
  input  wire [wedfr_pkg::CfgIdxW-1:0]           cfg_idx_i,
  input  wire [wedfr_pkg::CfgDataW-1:0]          cfg_data_i
);
  import wedfr_pkg::*;

  localparam int unsigned CntW  = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int unsigned FillW = $clog2(RING_DEPTH + 1);

  // Configuration registers
  logic [16:0] walpha_q, ralpha_q;
  logic [30:0] deadband_q, jump_q;
  logic [31:0] window_q, interval_q, minspan_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      walpha_q   <= WeightAlphaRst;
      deadband_q <= DeadbandRst;
      window_q   <= RateWindowRst;
      ralpha_q   <= RateAlphaRst;
      jump_q     <= JumpLimitRst;
      interval_q <= RateIntervalRst;
      minspan_q  <= MinSpanRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_WEIGHT_ALPHA:  walpha_q   <= cfg_data_i[16:0];
        CFG_DEADBAND:      deadband_q <= cfg_data_i[30:0];
        CFG_RATE_WINDOW:   window_q   <= cfg_data_i;
        CFG_RATE_ALPHA:    ralpha_q   <= cfg_data_i[16:0];
        CFG_JUMP_LIMIT:    jump_q     <= cfg_data_i[30:0];
        CFG_RATE_INTERVAL: interval_q <= cfg_data_i;
        CFG_MIN_SPAN:      minspan_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Control and filter state
  state_e             state_q, state_d;
  logic signed [31:0] raw_q, raw_d;
  logic [31:0]        now_q, now_d;
  logic signed [31:0] avg_q, avg_d, held_q, held_d;
  logic               primed_q, primed_d;
  logic [FillW-1:0]   fill_q, fill_d;
  logic [31:0]        last_q, last_d;
  logic signed [31:0] rnow_q, rnow_d, runs_q, runs_d;
  logic               upd_q, upd_d;
  logic [CntW-1:0]    cnt_q, cnt_d;
  logic               found_q, found_d;
  logic [31:0]        target_q, target_d;
  logic signed [31:0] wn_q, wn_d, wr_q, wr_d;
  logic [31:0]        tn_q, tn_d, tr_q, tr_d;
  logic [NumW-1:0]    num_q, num_d;
  logic [31:0]        rem_q, rem_d, span_q, span_d;
  logic               neg_q, neg_d;
  logic [DivCntW-1:0] dcnt_q, dcnt_d;
  logic               ovalid_q, ovalid_d;
  logic [127:0]       odata_q, odata_d;
  logic               oupd_q, oupd_d;

  // Ring of cells; cell 0 holds the newest entry between items
  chain_ctl_t         ctl;
  logic signed [31:0] cw [RING_DEPTH];
  logic [31:0]        ct [RING_DEPTH];

  for (genvar k = 0; k < RING_DEPTH; k++) begin : g_ring
    localparam int unsigned Nxt = (k + 1) % RING_DEPTH;
    if (k == 0) begin : g_head
      wedfr_cell u_cell (
        .clk_i, .ctl_i(ctl), .push_w_i(avg_q), .push_t_i(now_q),
        .rot_w_i(cw[Nxt]), .rot_t_i(ct[Nxt]), .w_o(cw[k]), .t_o(ct[k])
      );
    end else begin : g_body
      wedfr_cell u_cell (
        .clk_i, .ctl_i(ctl), .push_w_i(cw[k-1]), .push_t_i(ct[k-1]),
        .rot_w_i(cw[Nxt]), .rot_t_i(ct[Nxt]), .w_o(cw[k]), .t_o(ct[k])
      );
    end
  end

  // Combinational helpers
  logic signed [32:0] jd, dbd, dd;
  logic [32:0]        jmag, dbmag, dmag;
  logic [32:0]        rem_sh;
  logic               ge;
  logic [31:0]        span_c;
  logic signed [31:0] rsat;
  logic               take_ref;
  logic               out_free;

  always_comb begin
    jd       = 33'(raw_q) - 33'(avg_q);
    jmag     = jd[32] ? 33'(-jd) : 33'(jd);
    dbd      = 33'(avg_q) - 33'(held_q);
    dbmag    = dbd[32] ? 33'(-dbd) : 33'(dbd);
    dd       = 33'(wn_q) - 33'(wr_q);
    dmag     = dd[32] ? 33'(-dd) : 33'(dd);
    span_c   = tn_q - tr_q;
    rem_sh   = {rem_q, num_q[NumW-1]};
    ge       = rem_sh >= {1'b0, span_q};
    take_ref = (cnt_q != '0) && (FillW'(cnt_q) < fill_q) && !found_q &&
               ((ct[0] <= target_q) || (FillW'(cnt_q) == fill_q - FillW'(1)));
    if (neg_q) begin
      rsat = (num_q > NumW'(32'h8000_0000)) ? 32'sh8000_0000
                                            : signed'(~num_q[31:0] + 32'd1);
    end else begin
      rsat = (num_q > NumW'(32'h7FFF_FFFF)) ? 32'sh7FFF_FFFF : signed'(num_q[31:0]);
    end
    out_free = !ovalid_q || m_axis_tready;
  end

  // Sequencer
  always_comb begin
    state_d = state_q; raw_d = raw_q; now_d = now_q;
    avg_d = avg_q; held_d = held_q; primed_d = primed_q; fill_d = fill_q;
    last_d = last_q; rnow_d = rnow_q; runs_d = runs_q; upd_d = upd_q;
    cnt_d = cnt_q; found_d = found_q; target_d = target_q;
    wn_d = wn_q; wr_d = wr_q; tn_d = tn_q; tr_d = tr_q;
    num_d = num_q; rem_d = rem_q; span_d = span_q; neg_d = neg_q; dcnt_d = dcnt_q;
    ovalid_d = ovalid_q && !m_axis_tready;
    odata_d = odata_q; oupd_d = oupd_q;
    ctl = '{en: 1'b0, push: 1'b0};
    s_axis_tready = (state_q == ST_IDLE);

    case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          raw_d   = signed'(s_axis_tdata[31:0]);
          now_d   = s_axis_tdata[63:32];
          upd_d   = 1'b0;
          state_d = ST_WEIGHT;
          if (s_axis_tuser[0]) begin
            avg_d = '0; held_d = '0; primed_d = 1'b0; fill_d = '0;
            last_d = '0; rnow_d = '0; runs_d = '0;
            state_d = ST_DONE;
          end
        end
      end
      ST_WEIGHT: begin
        if (!primed_q || jmag > {2'b00, jump_q}) begin
          avg_d = raw_q; held_d = raw_q; primed_d = 1'b1;
        end else begin
          avg_d = ema_step(avg_q, raw_q, walpha_q);
        end
        state_d = ST_HOLD;
      end
      ST_HOLD: begin
        if (dbmag > {2'b00, deadband_q}) held_d = avg_q;
        ctl = '{en: 1'b1, push: 1'b1};
        if (fill_q != FillW'(RING_DEPTH)) fill_d = fill_q + FillW'(1);
        state_d = ST_DONE;
        if (fill_d >= FillW'(2) && (now_q - last_q) >= interval_q) begin
          last_d   = now_q;
          target_d = now_q - window_q;
          cnt_d    = '0;
          found_d  = 1'b0;
          state_d  = ST_SCAN;
        end
      end
      ST_SCAN: begin
        // cell 0 shows the entry that was cnt_q places back
        ctl = '{en: 1'b1, push: 1'b0};
        if (cnt_q == '0) begin
          wn_d = cw[0]; tn_d = ct[0];
        end
        if (take_ref) begin
          wr_d = cw[0]; tr_d = ct[0]; found_d = 1'b1;
        end
        cnt_d = cnt_q + CntW'(1);
        if (cnt_q == CntW'(RING_DEPTH - 1)) state_d = ST_MUL;
      end
      ST_MUL: begin
        span_d  = span_c;
        neg_d   = dd[32];
        num_d   = NumW'(dmag) * NumW'(1000) + NumW'(span_c >> 1);
        rem_d   = '0;
        dcnt_d  = '0;
        state_d = (span_c < minspan_q || span_c == '0) ? ST_DONE : ST_DIV;
      end
      ST_DIV: begin
        rem_d  = ge ? 32'(rem_sh - {1'b0, span_q}) : rem_sh[31:0];
        num_d  = {num_q[NumW-2:0], ge};
        dcnt_d = dcnt_q + DivCntW'(1);
        if (dcnt_q == DivCntW'(DivSteps - 1)) state_d = ST_RATE;
      end
      ST_RATE: begin
        runs_d  = rsat;
        rnow_d  = ema_step(rnow_q, rsat, ralpha_q);
        upd_d   = 1'b1;
        state_d = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) begin
          ovalid_d = 1'b1;
          odata_d  = {rnow_q, runs_q, held_q, avg_q};
          oupd_d   = upd_q;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      avg_q    <= '0;
      held_q   <= '0;
      primed_q <= 1'b0;
      fill_q   <= '0;
      last_q   <= '0;
      rnow_q   <= '0;
      runs_q   <= '0;
      cnt_q    <= '0;
      found_q  <= 1'b0;
      dcnt_q   <= '0;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      avg_q    <= avg_d;
      held_q   <= held_d;
      primed_q <= primed_d;
      fill_q   <= fill_d;
      last_q   <= last_d;
      rnow_q   <= rnow_d;
      runs_q   <= runs_d;
      cnt_q    <= cnt_d;
      found_q  <= found_d;
      dcnt_q   <= dcnt_d;
      ovalid_q <= ovalid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    raw_q    <= raw_d;
    now_q    <= now_d;
    upd_q    <= upd_d;
    target_q <= target_d;
    wn_q     <= wn_d;
    wr_q     <= wr_d;
    tn_q     <= tn_d;
    tr_q     <= tr_d;
    num_q    <= num_d;
    rem_q    <= rem_d;
    span_q   <= span_d;
    neg_q    <= neg_d;
    odata_q  <= odata_d;
    oupd_q   <= oupd_d;
  end

  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata  = odata_q;
  assign m_axis_tuser  = oupd_q;
endmodule
`default_nettype wire

// ===== rtl/wedfr_checker.sv =====
// Port-level checks for the weight filter, bound to the top level.
// Depends only on the top level's ports.
`default_nettype none
module wedfr_checker (
  input wire         clk_i,
  input wire         rst_ni,
  input wire         s_axis_tvalid,
  input wire         s_axis_tready,
  input wire         m_axis_tvalid,
  input wire         m_axis_tready,
  input wire [127:0] m_axis_tdata,
  input wire [0:0]   m_axis_tuser
);
  // A stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result changed while stalled");

  // An accepted item keeps the block busy for the next cycle
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("item accepted while previous one in progress");

  // A fresh result only follows a busy cycle
  a_res_after_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> !$past(s_axis_tready))
    else $error("result appeared without work");
endmodule

bind weight_ema_deadband_flow_rate_core wedfr_checker u_wedfr_checker (
  .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .m_axis_tvalid, .m_axis_tready,
  .m_axis_tdata, .m_axis_tuser
);
`default_nettype wire

// ===== bench/tb_weight_ema_deadband_flow_rate_core.sv =====
// Self-checking bench for weight_ema_deadband_flow_rate_core: directed, register-extreme,
// random, output-stall cases against an in-bench predictor of filter and flow rate.
// Depends on wedfr_pkg and the core RTL only.
`timescale 1ns / 1ps

module tb_weight_ema_deadband_flow_rate_core;
  import wedfr_pkg::*;

  localparam int RingDepth = 32;

  typedef struct {
    logic signed [31:0] filt;
    logic signed [31:0] shown;
    logic signed [31:0] rate_raw;
    logic signed [31:0] rate_smooth;
    logic               updated;
  } flow_result_t;

  logic         clk_i;
  logic         rst_ni;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [63:0]  s_axis_tdata;   // raw_weight, now_ms
  logic [0:0]   s_axis_tuser;   // action
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  logic [127:0] m_axis_tdata;   // filtered_weight, shown_weight, raw_rate, smooth_rate
  logic [0:0]   m_axis_tuser;   // rate_updated
  logic         cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgDataW-1:0] cfg_data_i;

  weight_ema_deadband_flow_rate_core uut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser,
    .cfg_we_i, .cfg_idx_i, .cfg_data_i
  );

  // Predictor copy of registers and filter state
  logic [16:0]        wt_alpha;
  logic [30:0]        deadband;
  logic [31:0]        window_ms;
  logic [16:0]        rt_alpha;
  logic [30:0]        jump_lim;
  logic [31:0]        interval_ms;
  logic [31:0]        span_min;
  logic signed [31:0] avg_w, held_w, rate_sm, rate_raw;
  logic               primed;
  int unsigned        wr_pos, fill;
  logic [31:0]        last_rate_ms;
  logic signed [31:0] ring_w[RingDepth];
  logic [31:0]        ring_t[RingDepth];

  flow_result_t pending_results[$];
  int  mismatches = 0;
  bit  idle_on = 1;
  bit  hold_req = 0;
  int  hold_left = 0;
  int  stall_left = 0;

  // Clock
  initial clk_i = 1'b0;
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Division rounded half away from zero
  function automatic longint div_half_away(longint n, longint d);
    longint m;
    longint q;
    m = (n < 0) ? -n : n;
    q = (m + d / 2) / d;
    return (n < 0) ? -q : q;
  endfunction

  function automatic logic signed [31:0] avg_step(logic signed [31:0] old, longint target,
                                                  logic [16:0] alpha);
    longint a;
    longint delta;
    a = (alpha > AlphaOne) ? 65536 : longint'(alpha);
    delta = target - longint'(old);
    return 32'(longint'(old) + div_half_away(delta * a, 65536));
  endfunction

  function automatic void clear_filter();
    avg_w = 0; held_w = 0; primed = 0; wr_pos = 0; fill = 0;
    last_rate_ms = 0; rate_sm = 0; rate_raw = 0;
  endfunction

  function automatic void set_reg(cfg_idx_e idx, logic [31:0] v);
    case (idx)
      CFG_WEIGHT_ALPHA:  wt_alpha    = v[16:0];
      CFG_DEADBAND:      deadband    = v[30:0];
      CFG_RATE_WINDOW:   window_ms   = v;
      CFG_RATE_ALPHA:    rt_alpha    = v[16:0];
      CFG_JUMP_LIMIT:    jump_lim    = v[30:0];
      CFG_RATE_INTERVAL: interval_ms = v;
      CFG_MIN_SPAN:      span_min    = v;
      default: ;
    endcase
  endfunction

  // Work out the result of one accepted item and update the state
  function automatic flow_result_t predict_flow(bit clr, logic signed [31:0] raw,
                                                logic [31:0] now);
    flow_result_t r;
    longint d, diff, q;
    int unsigned newest, ref_idx, idx;
    logic [31:0] target, span;
    bit upd;
    upd = 0;
    if (clr) begin
      clear_filter();
    end else begin
      if (!primed) begin
        avg_w = raw; held_w = raw; primed = 1;
      end else begin
        d = longint'(raw) - longint'(avg_w);
        if (d > longint'(jump_lim) || d < -longint'(jump_lim)) begin
          avg_w = raw; held_w = raw;
        end else begin
          avg_w = avg_step(avg_w, longint'(raw), wt_alpha);
        end
      end
      d = longint'(avg_w) - longint'(held_w);
      if (d > longint'(deadband) || d < -longint'(deadband)) held_w = avg_w;
      ring_w[wr_pos] = avg_w;
      ring_t[wr_pos] = now;
      wr_pos = (wr_pos + 1) % RingDepth;
      if (fill < RingDepth) fill++;
      if (fill >= 2 && 32'(now - last_rate_ms) >= interval_ms) begin
        newest  = (wr_pos + RingDepth - 1) % RingDepth;
        target  = now - window_ms;
        ref_idx = (wr_pos + RingDepth - fill) % RingDepth;
        last_rate_ms = now;
        for (int i = 1; i < fill; i++) begin
          idx = (wr_pos + 2 * RingDepth - 1 - i) % RingDepth;
          if (ring_t[idx] <= target) begin
            ref_idx = idx;
            break;
          end
        end
        span = ring_t[newest] - ring_t[ref_idx];
        if (span >= span_min && span != 0) begin
          diff = longint'(ring_w[newest]) - longint'(ring_w[ref_idx]);
          q = div_half_away(diff * 1000, longint'(span));
          if (q > 64'sd2147483647) q = 64'sd2147483647;
          if (q < -64'sd2147483648) q = -64'sd2147483648;
          rate_raw = 32'(q);
          rate_sm = avg_step(rate_sm, q, rt_alpha);
          upd = 1;
        end
      end
    end
    r.filt = avg_w; r.shown = held_w; r.rate_raw = rate_raw;
    r.rate_smooth = rate_sm; r.updated = upd;
    return r;
  endfunction

  // Offer one item, wait for acceptance, maybe pause afterwards
  task automatic send_item(bit clr, logic signed [31:0] raw, logic [31:0] now);
    s_axis_tdata  <= {now, raw};
    s_axis_tuser  <= clr;
    s_axis_tvalid <= 1'b1;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    pending_results.push_back(predict_flow(clr, raw, now));
    if (idle_on && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk_i);
    end
  endtask

  task automatic wait_drain();
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
  endtask

  task automatic cfg_write(cfg_idx_e idx, logic [31:0] v);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= v;
    @(posedge clk_i);
    set_reg(idx, v);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic cfg_all(logic [31:0] wa, logic [31:0] db, logic [31:0] win,
                         logic [31:0] ra, logic [31:0] jl, logic [31:0] iv, logic [31:0] ms);
    wait_drain();
    cfg_write(CFG_WEIGHT_ALPHA, wa);
    cfg_write(CFG_DEADBAND, db);
    cfg_write(CFG_RATE_WINDOW, win);
    cfg_write(CFG_RATE_ALPHA, ra);
    cfg_write(CFG_JUMP_LIMIT, jl);
    cfg_write(CFG_RATE_INTERVAL, iv);
    cfg_write(CFG_MIN_SPAN, ms);
  endtask

  // A stream of plausible scale samples: a random walk with occasional jumps,
  // timestamp glitches and clears
  task automatic run_samples(int n, int step_w, int step_t);
    logic signed [31:0] w;
    logic [31:0] t;
    int sel;
    w = $urandom();
    w = w >>> $urandom_range(0, 31);
    t = $urandom();
    send_item(1'b1, $urandom(), $urandom());
    for (int i = 0; i < n; i++) begin
      sel = $urandom_range(0, 99);
      if (sel < 2) begin
        send_item(1'b1, $urandom(), $urandom());
      end else begin
        if (sel < 6) w = $urandom();
        else w = w + $signed($urandom_range(0, 2 * step_w)) - step_w;
        if (sel >= 97) t = $urandom();
        else t = t + $urandom_range(0, step_t);
        send_item(1'b0, w, t);
      end
    end
  endtask

  task automatic test_directed();
    logic [31:0] t;
    t = 32'hFFFF_FD00;                          // crosses the timestamp wrap
    send_item(1'b0, 32'sh7FFF_FFFF, t);        // primes at the largest weight
    send_item(1'b0, 32'sh8000_0000, t + 50);   // far beyond the jump limit
    send_item(1'b1, 0, 0);
    send_item(1'b0, 1000, t);
    for (int i = 1; i <= 14; i++) send_item(1'b0, 1000 + 40 * i, t + 100 * i);
    send_item(1'b0, 1600, t + 1400);           // same time again, interval short: no rate
    send_item(1'b0, 1610, t + 1401);           // deadband edge, interval short
    send_item(1'b0, -1000, t + 1700);
    send_item(1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
  endtask

  task automatic test_register_extremes();
    cfg_all(0, 0, 0, 0, 0, 0, 0);
    run_samples(40, 300, 100);
    cfg_all(32'h0001_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h0001_0000,
            32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    run_samples(40, 300, 100);
    // coefficients above one, tiny span: rate saturates on big swings
    cfg_all(32'h0001_FFFF, 0, 0, 32'h0001_FFFF, 32'h7FFF_FFFF, 0, 1);
    send_item(1'b1, 0, 0);
    send_item(1'b0, 32'sh8000_0000, 10);
    send_item(1'b0, 32'sh7FFF_FFFF, 11);
    send_item(1'b0, 32'sh8000_0000, 12);
    run_samples(40, 1 << 30, 5);
    cfg_all($urandom(), $urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
            $urandom());
    run_samples(30, 2000, 400);
  endtask

  task automatic test_random();
    for (int p = 0; p < 9; p++) begin
      if (p == 8) idle_on = 0;
      cfg_all($urandom_range(0, 70000), $urandom_range(0, 3000), $urandom_range(0, 2000),
              $urandom_range(0, 70000), $urandom_range(0, 5000), $urandom_range(0, 500),
              $urandom_range(0, 400));
      run_samples(90, $urandom_range(1, 2000), $urandom_range(1, 300));
    end
  endtask

  task automatic test_output_stall();
    hold_req = 1;
    run_samples(20, 200, 150);
  endtask

  // Result side: comparison against the predictor
  always @(posedge clk_i) begin
    flow_result_t e;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result item %h", m_axis_tdata);
      end else begin
        e = pending_results.pop_front();
        if (m_axis_tdata[31:0] !== e.filt || m_axis_tdata[63:32] !== e.shown ||
            m_axis_tdata[95:64] !== e.rate_raw || m_axis_tdata[127:96] !== e.rate_smooth ||
            m_axis_tuser[0] !== e.updated) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch filt %0d/%0d shown %0d/%0d raw %0d/%0d smooth %0d/%0d upd %b/%b",
                     e.filt, $signed(m_axis_tdata[31:0]), e.shown,
                     $signed(m_axis_tdata[63:32]), e.rate_raw,
                     $signed(m_axis_tdata[95:64]), e.rate_smooth,
                     $signed(m_axis_tdata[127:96]), e.updated, m_axis_tuser[0]);
        end
      end
    end
  end

  // Result side: random stalls and the long hold-off
  always @(posedge clk_i) begin
    if (hold_req) begin
      hold_req = 0;
      hold_left = 600;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      m_axis_tready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 7) == 0) begin
      stall_left = $urandom_range(1, 14) - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  initial begin
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0; s_axis_tdata = '0; s_axis_tuser = '0;
    m_axis_tready = 1'b0;
    cfg_we_i = 1'b0; cfg_idx_i = CFG_WEIGHT_ALPHA; cfg_data_i = '0;
    wt_alpha = WeightAlphaRst; deadband = DeadbandRst; window_ms = RateWindowRst;
    rt_alpha = RateAlphaRst; jump_lim = JumpLimitRst; interval_ms = RateIntervalRst;
    span_min = MinSpanRst;
    clear_filter();
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);
    test_directed();
    test_output_stall();
    test_register_extremes();
    test_random();
    wait_drain();
    if (mismatches == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

  // Run limit
  initial begin
    #20_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/wedfr_pkg.sv
rtl/wedfr_cell.sv
rtl/weight_ema_deadband_flow_rate_core.sv
rtl/wedfr_checker.sv
bench/tb_weight_ema_deadband_flow_rate_core.sv
